/* src/apc_pkg.sv */
// apc_pkg: shared constants, types and arithmetic helpers of the admittance
// position controller. No dependencies; every other file of the block imports it.
`default_nettype none

package apc_pkg;

  // fixed-point format of the work values
  localparam int FRAC_BITS = 16;

  // field and register widths
  localparam int POS_W     = 32;
  localparam int CUR_W     = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = 64;
  localparam int HALF_W    = ACC_W / 2;

  // filter state stays below 2^(FRAC_BITS+13) in magnitude, plus a sign bit
  localparam int FF_W = FRAC_BITS + 14;

  // filter coefficients 0.18 and 0.02, rounded to nearest
  localparam int COEF_NEW = ((18 << FRAC_BITS) + 50) / 100;
  localparam int COEF_OLD = ((2 << FRAC_BITS) + 50) / 100;
  localparam int COEF_W   = $clog2(COEF_NEW + 1) + 1;

  localparam logic signed [COEF_W-1:0] COEF_NEW_C = COEF_W'(COEF_NEW);
  localparam logic signed [COEF_W-1:0] COEF_OLD_C = COEF_W'(COEF_OLD);

  // rescale of the spring term (Q16) and the damping term (Q17)
  localparam int SPRING_SHIFT = FRAC_BITS - 16;
  localparam int DAMP_SHIFT   = FRAC_BITS - 17;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0]        ACC_ONES = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0]        FRAC_MASK =
    {{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  localparam logic signed [ACC_W-1:0] SP_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SP_MIN = -ACC_W'(64'sd2147483648);

  // register reset values
  localparam logic [CFG_W-1:0] STIFFNESS_RST    = 32'd19661;
  localparam logic [CFG_W-1:0] DAMPING_RST      = 32'd52428800;
  localparam logic [CFG_W-1:0] INVERSE_MASS_RST = 32'd715828;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFFNESS    = 2'd0,
    CFG_DAMPING      = 2'd1,
    CFG_INVERSE_MASS = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPRING,
    ST_DAMP,
    ST_SUM,
    ST_MAG,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACCEL,
    ST_VEL,
    ST_POS,
    ST_OUT
  } state_e;

  // controller to datapath commands, one step each
  typedef struct packed {
    logic load;
    logic mul_spring;
    logic mul_damp;
    logic add_spring;
    logic add_damp;
    logic take_mag;
    logic mul_lo;
    logic mul_hi;
    logic form_accel;
    logic upd_vel;
    logic upd_pos;
    logic write_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } status_t;

  // saturated value with its clip flag
  typedef struct packed {
    logic signed [ACC_W-1:0] val;
    logic                    clip;
  } sat_t;

  // signed value from sign and magnitude, rescaled by a constant shift
  function automatic sat_t from_mag(input logic neg, input logic [ACC_W-1:0] mag_in,
                                    input int shift);
    sat_t              r;
    logic [ACC_W-1:0]  mag;
    logic              big;
    r.clip = 1'b0;
    r.val  = '0;
    mag    = mag_in;
    big    = 1'b0;
    if (shift < 0) begin
      mag = mag_in >> (-shift);
    end else if (shift > 0) begin
      big = (mag_in > (ACC_ONES >> shift));
      mag = mag_in << shift;
    end
    if (big) begin
      r.clip = 1'b1;
      r.val  = neg ? ACC_MIN : ACC_MAX;
    end else if (!neg) begin
      if (mag[ACC_W-1]) begin
        r.clip = 1'b1;
        r.val  = ACC_MAX;
      end else begin
        r.val = mag;
      end
    end else begin
      if (mag > ACC_MIN) begin
        r.clip = 1'b1;
        r.val  = ACC_MIN;
      end else begin
        r.val = -mag;
      end
    end
    return r;
  endfunction

  // saturating signed add
  function automatic sat_t sat_add(input logic signed [ACC_W-1:0] a,
                                   input logic signed [ACC_W-1:0] b);
    sat_t                    r;
    logic signed [ACC_W-1:0] s;
    s      = a + b;
    r.clip = 1'b0;
    r.val  = s;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      r.clip = 1'b1;
      r.val  = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return r;
  endfunction

  // magnitude of a signed work value
  function automatic logic [ACC_W-1:0] magnitude(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
  endfunction

endpackage

`default_nettype wire

/* src/apc_if.sv */
// apc_in_if / apc_out_if: valid-ready channels of the admittance controller.
// Depends on apc_pkg for the field widths.
`default_nettype none

interface apc_in_if import apc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;
  logic signed [CUR_W-1:0] current;

  modport source (output valid, output position, output current, input ready);
  modport sink (input valid, input position, input current, output ready);
endinterface

interface apc_out_if import apc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] setpoint;
  logic                    clipped;

  modport source (output valid, output setpoint, output clipped, input ready);
  modport sink (input valid, input setpoint, input clipped, output ready);
endinterface

`default_nettype wire

/* src/apc_ctrl.sv */
// apc_ctrl: sequencer of one control tick, steps the datapath through
// filter, force sum, acceleration and the two integrators. Depends on apc_pkg.
`default_nettype none

module apc_ctrl import apc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and step commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SPRING;
        end
      end
      ST_SPRING: begin
        cmd_o.mul_spring = 1'b1;
        state_d          = ST_DAMP;
      end
      ST_DAMP: begin
        cmd_o.mul_damp   = 1'b1;
        cmd_o.add_spring = 1'b1;
        state_d          = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.add_damp = 1'b1;
        state_d        = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.take_mag = 1'b1;
        state_d        = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_ACCEL;
      end
      ST_ACCEL: begin
        cmd_o.form_accel = 1'b1;
        state_d          = ST_VEL;
      end
      ST_VEL: begin
        cmd_o.upd_vel = 1'b1;
        state_d       = ST_POS;
      end
      ST_POS: begin
        cmd_o.upd_pos = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.write_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/apc_datapath.sv */
// apc_datapath: registers, force filter, shared 32x32 multiplier, saturating
// adders, integrators and the result register. Depends on apc_pkg.
`default_nettype none

module apc_datapath import apc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  output status_t                     status_o,
  input  logic signed [POS_W-1:0]     position_i,
  input  logic signed [CUR_W-1:0]     current_i,
  input  logic                        cfg_we_i,
  input  logic        [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [CFG_W-1:0]     cfg_data_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic signed [POS_W-1:0]     out_setpoint_o,
  output logic                        out_clipped_o
);

  // configuration
  logic [CFG_W-1:0] stiffness_q, damping_q, inverse_mass_q;

  // tick-to-tick state
  logic signed [POS_W-1:0] prev_pos_q;
  logic signed [FF_W-1:0]  ff_q, ff_d;
  logic signed [ACC_W-1:0] vel_q, pacc_q;

  // per-tick working registers
  logic        [POS_W-1:0]  pos_mag_q, pos_mag_d;
  logic                     pos_pos_q;
  logic signed [POS_W:0]    diff_q, diff_d;
  logic        [POS_W-1:0]  diff_mag_q, diff_mag_d;
  logic                     diff_pos_q;
  logic        [ACC_W-1:0]  prod_q, prod_d;
  logic        [HALF_W-1:0] part_q;
  logic signed [ACC_W-1:0]  sum_q;
  logic        [ACC_W-1:0]  mag_q;
  logic                     neg_q;
  logic signed [ACC_W-1:0]  accel_q;
  logic                     clip_q;

  // result register
  logic                    out_valid_q;
  logic signed [POS_W-1:0] out_setpoint_q;
  logic                    out_clipped_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiffness_q    <= STIFFNESS_RST;
      damping_q      <= DAMPING_RST;
      inverse_mass_q <= INVERSE_MASS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STIFFNESS:    stiffness_q    <= cfg_data_i;
        CFG_DAMPING:      damping_q      <= cfg_data_i;
        CFG_INVERSE_MASS: inverse_mass_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // force filter: 0.18 * (-current) + 0.02 * old, old term truncated toward zero
  logic signed [CUR_W:0]               cur_ext, cur_neg;
  logic signed [CUR_W+COEF_W:0]        new_term;
  logic signed [FF_W+COEF_W-1:0]       decay_prod, decay_bias;
  logic signed [FF_W-1:0]              decay;

  always_comb begin
    cur_ext    = {current_i[CUR_W-1], current_i};
    cur_neg    = -cur_ext;
    new_term   = cur_neg * COEF_NEW_C;
    decay_prod = ff_q * COEF_OLD_C;
    decay_bias = decay_prod + (decay_prod[FF_W+COEF_W-1] ?
                 (FF_W+COEF_W)'(FRAC_MASK) : (FF_W+COEF_W)'(0));
    decay      = FF_W'(decay_bias >>> FRAC_BITS);
    ff_d       = FF_W'(new_term + decay);
  end

  // input magnitudes and position change
  logic signed [POS_W:0] pos_ext, prev_ext;

  always_comb begin
    pos_ext    = {position_i[POS_W-1], position_i};
    prev_ext   = {prev_pos_q[POS_W-1], prev_pos_q};
    pos_mag_d  = position_i[POS_W-1] ? POS_W'(-pos_ext) : POS_W'(position_i);
    diff_d     = pos_ext - prev_ext;
    diff_mag_d = diff_q[POS_W] ? POS_W'(-diff_q) : POS_W'(diff_q);
  end

  // shared multiplier
  logic [HALF_W-1:0] mul_a, mul_b;

  always_comb begin
    mul_a = mag_q[ACC_W-1:HALF_W];
    mul_b = inverse_mass_q;
    if (cmd_i.mul_spring) begin
      mul_a = pos_mag_q;
      mul_b = stiffness_q;
    end else if (cmd_i.mul_damp) begin
      mul_a = diff_mag_q;
      mul_b = damping_q;
    end else if (cmd_i.mul_lo) begin
      mul_a = mag_q[HALF_W-1:0];
    end
    prod_d = ACC_W'(mul_a) * ACC_W'(mul_b);
  end

  // force sum, acceleration and integrator steps
  sat_t spring_term, spring_sum, damp_term, damp_sum, accel_term, vel_sum, pos_sum;

  always_comb begin
    spring_term = from_mag(pos_pos_q, prod_q, SPRING_SHIFT);
    spring_sum  = sat_add(ACC_W'(ff_q), spring_term.val);
    damp_term   = from_mag(diff_pos_q, prod_q, DAMP_SHIFT);
    damp_sum    = sat_add(sum_q, damp_term.val);
    accel_term  = from_mag(neg_q, prod_q + ACC_W'(part_q), 0);
    vel_sum     = sat_add(vel_q, accel_q);
    pos_sum     = sat_add(pacc_q, vel_q);
  end

  // setpoint: integer part truncated toward zero, saturated to 32 bits
  logic signed [ACC_W-1:0] pacc_bias, sp_wide;
  logic signed [POS_W-1:0] sp;
  logic                    sp_clip;

  always_comb begin
    pacc_bias = pacc_q + (pacc_q[ACC_W-1] ? FRAC_MASK : '0);
    sp_wide   = pacc_bias >>> FRAC_BITS;
    sp_clip   = 1'b1;
    if (sp_wide > SP_MAX) begin
      sp = POS_W'(SP_MAX);
    end else if (sp_wide < SP_MIN) begin
      sp = POS_W'(SP_MIN);
    end else begin
      sp      = POS_W'(sp_wide);
      sp_clip = 1'b0;
    end
  end

  // state carried from tick to tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pos_q <= '0;
      ff_q       <= '0;
      vel_q      <= '0;
      pacc_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        prev_pos_q <= position_i;
        ff_q       <= ff_d;
      end
      if (cmd_i.upd_vel) begin
        vel_q <= vel_sum.val;
      end
      if (cmd_i.upd_pos) begin
        pacc_q <= pos_sum.val;
      end
    end
  end

  // working registers of the current tick
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_mag_q <= pos_mag_d;
      pos_pos_q <= !position_i[POS_W-1] && (position_i != '0);
      diff_q    <= diff_d;
      clip_q    <= 1'b0;
    end
    if (cmd_i.mul_spring) begin
      diff_mag_q <= diff_mag_d;
      diff_pos_q <= !diff_q[POS_W] && (diff_q != '0);
    end
    if (cmd_i.mul_spring || cmd_i.mul_damp || cmd_i.mul_lo || cmd_i.mul_hi) begin
      prod_q <= prod_d;
    end
    if (cmd_i.mul_hi) begin
      part_q <= prod_q[ACC_W-1:HALF_W];
    end
    if (cmd_i.add_spring) begin
      sum_q  <= spring_sum.val;
      clip_q <= clip_q | spring_term.clip | spring_sum.clip;
    end
    if (cmd_i.add_damp) begin
      sum_q  <= damp_sum.val;
      clip_q <= clip_q | damp_term.clip | damp_sum.clip;
    end
    if (cmd_i.take_mag) begin
      mag_q <= magnitude(sum_q);
      neg_q <= sum_q[ACC_W-1];
    end
    if (cmd_i.form_accel) begin
      accel_q <= accel_term.val;
      clip_q  <= clip_q | accel_term.clip;
    end
    if (cmd_i.upd_vel) begin
      clip_q <= clip_q | vel_sum.clip;
    end
    if (cmd_i.upd_pos) begin
      clip_q <= clip_q | pos_sum.clip;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_out) begin
      out_setpoint_q <= sp;
      out_clipped_q  <= clip_q | sp_clip;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_setpoint_o    = out_setpoint_q;
  assign out_clipped_o     = out_clipped_q;

endmodule

`default_nettype wire

/* src/admittance_position_controller_core.sv */
// admittance_position_controller_core: top level of the admittance controller.
// Depends on apc_pkg, apc_if, apc_ctrl and apc_datapath.
`default_nettype none

// One transfer on the input channel is one control tick: measured position and
// motor current go in, one position setpoint with a clip flag comes out. A tick is
// the accept cycle and then ten steps of the sequencer, which runs the spring,
// damping and two acceleration partial products one after another through a single
// 32x32 multiplier and then the two saturating integrator updates. The block takes
// one tick at a time; in_ch.ready is high whenever no tick is in progress, and a
// result still held in the output register only delays the end of the following
// tick. Stiffness, damping and inverse mass are to be written by the user through
// the configuration port while the block is idle; the block does not enforce it.
module admittance_position_controller_core import apc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  apc_in_if.sink               in_ch,
  apc_out_if.source            out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  apc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic and registers
  apc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .position_i     (in_ch.position),
    .current_i      (in_ch.current),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (out_ch.ready),
    .out_valid_o    (out_ch.valid),
    .out_setpoint_o (out_ch.setpoint),
    .out_clipped_o  (out_ch.clipped)
  );

endmodule

`default_nettype wire

/* src/apc_checker.sv */
// apc_checker: port-level assertions of the admittance controller, bound to
// the top level. Depends on apc_pkg and admittance_position_controller_core.
`default_nettype none

module apc_checker import apc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [POS_W-1:0] out_setpoint_i,
  input logic             out_clipped_i
);

  // a held result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_setpoint_i) && $stable(out_clipped_i))
    else $error("result payload changed while stalled");

  // one tick at a time: no new input right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a tick is in progress");

  // a new result appears only at the end of a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while the block was idle");

endmodule

bind admittance_position_controller_core apc_checker u_apc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_ch.valid),
  .in_ready_i     (in_ch.ready),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .out_setpoint_i (out_ch.setpoint),
  .out_clipped_i  (out_ch.clipped)
);

`default_nettype wire
